// ----- rtl/core/ordered_insert_remove_list_core_assert.svh -----
// Assertion macros for the list core datapath.
// Both take the clock clk and the synchronous reset rst from the enclosing module.
`ifndef ORDERED_INSERT_REMOVE_LIST_CORE_ASSERT_SVH
`define ORDERED_INSERT_REMOVE_LIST_CORE_ASSERT_SVH

// Same-cycle implication.
`define OIRL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OIRL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/oirl_pkg.sv -----
// ----------------------------------------------------------------------------
// oirl_pkg
// Types, constants and control structs for the ordered insert/remove list.
// ----------------------------------------------------------------------------
package oirl_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 6;
  localparam int LIMIT_W    = 7;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_FETCH,
    S_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic move_rd;
    logic move_wr;
    logic put;
    logic fetch;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    dec_ok;
    logic    more_now;
    logic    more_step;
    logic    out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/oirl_req_if.sv -----
// ----------------------------------------------------------------------------
// oirl_req_if
// Request channel: one list action per beat.
// ----------------------------------------------------------------------------
interface oirl_req_if import oirl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [POS_W-1:0]      position;
  logic                  use_last;
  logic [ELEM_WIDTH-1:0] element;

  modport source (output valid, output action, output position, output use_last,
                  output element, input ready);
  modport sink   (input valid, input action, input position, input use_last,
                  input element, output ready);
endinterface

// ----- rtl/core/oirl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// oirl_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
interface oirl_rsp_if import oirl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [ELEM_WIDTH-1:0] read_element;
  logic [CNT_W-1:0]      entry_count;
  logic                  is_full;
  logic                  is_empty;

  modport source (output valid, output status, output read_element,
                  output entry_count, output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input read_element,
                  input entry_count, input is_full, input is_empty, output ready);
endinterface

// ----- rtl/core/ordered_insert_remove_list_core.sv -----
// ----------------------------------------------------------------------------
// ordered_insert_remove_list_core
// Bounded ordered list with insert, remove and read at an index.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one action per beat (clear, insert, remove, read) with a
//   position, a use-last flag and the element to insert. rsp returns one beat
//   per request: status, read element, count after the action, full, empty.
//   cfg_we/cfg_data write the capacity limit (values above 64 act as 64);
//   write it only while no request is in flight.
// Sequencing:
//   One request at a time. Clear and failed actions go from decode straight to
//   the result; a read fetches the entry first. Insert and remove check for
//   entries to shift and move each one (up to 63) with a read and then a write
//   on the entry memory; insert then puts the new element. The next request
//   is accepted once the result is registered.
// Reset:
//   rst clears the count and sets the capacity limit to 64. Entry contents
//   are not cleared; no initialization pass is needed.
// Stall:
//   A finished result sits in the output register; the next request is still
//   accepted and worked, and its result waits until rsp.ready takes the beat.
// ----------------------------------------------------------------------------
module ordered_insert_remove_list_core import oirl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  oirl_req_if.sink           req,
  oirl_rsp_if.source         rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  assign req.ready = ready;

  oirl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oirl_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .act_in   (req.action),
    .pos_in   (req.position),
    .last_in  (req.use_last),
    .elem_in  (req.element),
    .cmd      (cmd),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

// ----- rtl/core/oirl_ctrl.sv -----
// ----------------------------------------------------------------------------
// oirl_ctrl
// Sequencer: decodes an action, steps entry moves one read/write pair at a
// time, and hands the result to the output register.
// ----------------------------------------------------------------------------
module oirl_ctrl import oirl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.dec_ok || stat.act == ACT_CLEAR) begin
          state_next = S_RESULT;
        end else if (stat.act == ACT_READ) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.more_now) begin
          state_next = S_MOVE_RD;
        end else if (stat.act == ACT_INSERT) begin
          state_next = S_PUT;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR: begin
        if (stat.more_step) begin
          state_next = S_MOVE_RD;
        end else if (stat.act == ACT_INSERT) begin
          state_next = S_PUT;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_PUT:   state_next = S_RESULT;
      S_FETCH: state_next = S_RESULT;
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_DECODE:  cmd.decode  = 1'b1;
      S_MOVE_RD: cmd.move_rd = 1'b1;
      S_MOVE_WR: cmd.move_wr = 1'b1;
      S_PUT:     cmd.put     = 1'b1;
      S_FETCH:   cmd.fetch   = 1'b1;
      S_RESULT:  cmd.emit    = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/oirl_datapath.sv -----
// ----------------------------------------------------------------------------
// oirl_datapath
// Entry memory, count, capacity register, position decode and the output
// register of the response channel.
// ----------------------------------------------------------------------------
module oirl_datapath import oirl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LIMIT_W-1:0]    cfg_data,
  input  logic [1:0]            act_in,
  input  logic [POS_W-1:0]      pos_in,
  input  logic                  last_in,
  input  logic [ELEM_WIDTH-1:0] elem_in,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  oirl_rsp_if.source            rsp
);

  `include "ordered_insert_remove_list_core_assert.svh"

  logic [ELEM_WIDTH-1:0] mem [CAPACITY];
  logic [ELEM_WIDTH-1:0] rdata;

  logic [LIMIT_W-1:0]    capacity_limit;
  logic [CNT_W-1:0]      count;
  action_t               act;
  logic [POS_W-1:0]      pos;
  logic                  last;
  logic [ELEM_WIDTH-1:0] elem;
  logic [CNT_W-1:0]      peff;
  logic [CNT_W-1:0]      idx;
  status_t               stat_code;
  logic                  out_valid;

  logic [CNT_W-1:0]      dec_pos;
  logic                  dec_pos_ok;
  status_t               dec_stat;
  logic [LIMIT_W-1:0]    eff_limit;
  logic                  at_limit;
  logic [CNT_W:0]        idx_plus1;
  logic [CNT_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      wr_addr;

  assign eff_limit = (capacity_limit > LIMIT_W'(CAPACITY)) ? LIMIT_W'(CAPACITY)
                                                          : capacity_limit;
  assign at_limit  = LIMIT_W'(count) >= eff_limit;

  // Resolve the effective position and status for this action
  always_comb begin
    dec_pos    = {1'b0, pos};
    dec_pos_ok = 1'b1;
    if (last) begin
      if (act == ACT_INSERT) begin
        dec_pos = count;
      end else begin
        dec_pos    = count - CNT_W'(1);
        dec_pos_ok = (count != '0);
      end
    end
    case (act)
      ACT_CLEAR:  dec_stat = ST_OK;
      ACT_INSERT: begin
        if (dec_pos > count) begin
          dec_stat = ST_INVALID;
        end else if (at_limit) begin
          dec_stat = ST_FULL;
        end else begin
          dec_stat = ST_OK;
        end
      end
      default: begin
        dec_stat = (!dec_pos_ok || dec_pos >= count) ? ST_INVALID : ST_OK;
      end
    endcase
  end

  assign idx_plus1 = {1'b0, idx} + (CNT_W+1)'(1);

  // A remove has already dropped the count, so move while idx is below it
  assign stat.act      = act;
  assign stat.dec_ok   = (dec_stat == ST_OK);
  assign stat.more_now = (act == ACT_INSERT) ? (idx > peff)
                                             : (idx < count);
  assign stat.more_step = (act == ACT_INSERT) ? ((idx - CNT_W'(1)) > peff)
                                              : (idx_plus1 < {1'b0, count});
  assign stat.out_free = !out_valid || rsp.ready;

  assign rd_addr = cmd.fetch ? peff
                 : ((act == ACT_INSERT) ? (idx - CNT_W'(1)) : idx_plus1[CNT_W-1:0]);
  assign wr_addr = cmd.put ? peff : idx;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.move_wr) begin
      mem[wr_addr[ADDR_W-1:0]] <= rdata;
    end else if (cmd.put) begin
      mem[wr_addr[ADDR_W-1:0]] <= elem;
    end
    if (cmd.move_rd || cmd.fetch) begin
      rdata <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // Latched item and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action_t'(act_in);
      pos  <= pos_in;
      last <= last_in;
      elem <= elem_in;
    end
    if (cmd.decode) begin
      stat_code <= dec_stat;
      peff      <= dec_pos;
      if (act == ACT_INSERT) begin
        idx <= count;
      end else begin
        idx <= dec_pos;
      end
    end else if (cmd.move_wr) begin
      idx <= (act == ACT_INSERT) ? (idx - CNT_W'(1)) : idx_plus1[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_W'(CAPACITY);
      count          <= '0;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_data;
      end
      if (cmd.decode && dec_stat == ST_OK) begin
        if (act == ACT_CLEAR) begin
          count <= '0;
        end else if (act == ACT_REMOVE) begin
          count <= count - CNT_W'(1);
        end
      end else if (cmd.put) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status       <= stat_code;
      rsp.read_element <= (act == ACT_READ && stat_code == ST_OK) ? rdata : '0;
      rsp.entry_count  <= count;
      rsp.is_full      <= at_limit;
      rsp.is_empty     <= (count == '0);
    end
  end

  assign rsp.valid = out_valid;

  `OIRL_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `OIRL_ASSERT_NEXT(a_put_inc, cmd.put, count == $past(count) + CNT_W'(1), "insert lost count")
  `OIRL_ASSERT_NOW(a_move_range, cmd.move_wr, idx < CNT_W'(CAPACITY), "move index out of range")
  `OIRL_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid || rsp.ready, "result overwrote pending beat")

endmodule
